// ----- rtl/byte_frame_deframer_assert.svh -----
`ifndef BYTE_FRAME_DEFRAMER_ASSERT_SVH
`define BYTE_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BFD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfd assertion failed");

// Next-cycle implication, checked out of reset.
`define BFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfd assertion failed");

`endif

// ----- rtl/bfd_pkg.sv -----
`timescale 1ns / 1ps

package bfd_pkg;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE   = 1'd1;

    localparam logic [7:0] START_BYTE_RST = 8'hAA;
    localparam logic [7:0] END_BYTE_RST   = 8'h55;

    // Frame handed from the parser to the emitter.
    typedef struct packed {
        logic        start;
        logic [15:0] id;
        logic [15:0] crc;
        logic [7:0]  len;
    } t_emit_req;

endpackage

// ----- rtl/bfd_ram.sv -----
`timescale 1ns / 1ps

module bfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bfd_parser.sv -----
`timescale 1ns / 1ps

module bfd_parser #(
    parameter int MAX_PAYLOAD = 16,
    parameter int LEN_W       = $clog2(MAX_PAYLOAD + 1),
    parameter int AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [7:0]                    i_rx_byte,
    input  logic                          i_cfg_we,
    input  logic [bfd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                    i_cfg_data,
    output logic                          o_ram_we,
    output logic [AW-1:0]                 o_ram_waddr,
    output logic [7:0]                    o_ram_wdata,
    output bfd_pkg::t_emit_req            o_req
);

    import bfd_pkg::*;

    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_ID   = 3'd1;
    localparam logic [2:0] PH_LEN  = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_CRC  = 3'd4;
    localparam logic [2:0] PH_END  = 3'd5;

    logic [7:0]       r_start_byte, r_end_byte;
    logic [2:0]       r_phase, n_phase;
    logic [LEN_W-1:0] r_cnt, n_cnt;
    logic [15:0]      r_id, n_id;
    logic [LEN_W-1:0] r_len, n_len;
    logic [15:0]      r_crc, n_crc;
    logic             n_start;
    logic             n_we;
    logic [LEN_W-1:0] w_cnt_inc;

    assign w_cnt_inc = LEN_W'(r_cnt + 1'b1);

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_id    = r_id;
        n_len   = r_len;
        n_crc   = r_crc;
        n_start = 1'b0;
        n_we    = 1'b0;
        if (i_accept) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == r_start_byte) begin
                        n_phase = PH_ID;
                        n_cnt   = '0;
                    end
                end
                PH_ID: begin
                    if (r_cnt == '0) begin
                        n_id[7:0] = i_rx_byte;
                        n_cnt     = LEN_W'(1);
                    end else begin
                        n_id[15:8] = i_rx_byte;
                        n_cnt      = '0;
                        n_phase    = PH_LEN;
                    end
                end
                PH_LEN: begin
                    // drop oversized frames and hunt again
                    if (32'(i_rx_byte) > 32'(MAX_PAYLOAD)) begin
                        n_phase = PH_HUNT;
                    end else begin
                        n_len   = LEN_W'(i_rx_byte);
                        n_cnt   = '0;
                        n_phase = (i_rx_byte == 8'd0) ? PH_CRC : PH_DATA;
                    end
                end
                PH_DATA: begin
                    n_we = 1'b1;
                    if (w_cnt_inc >= r_len) begin
                        n_cnt   = '0;
                        n_phase = PH_CRC;
                    end else begin
                        n_cnt = w_cnt_inc;
                    end
                end
                PH_CRC: begin
                    if (r_cnt == '0) begin
                        n_crc[7:0] = i_rx_byte;
                        n_cnt      = LEN_W'(1);
                    end else begin
                        n_crc[15:8] = i_rx_byte;
                        n_cnt       = '0;
                        n_phase     = PH_END;
                    end
                end
                PH_END: begin
                    n_start = (i_rx_byte == r_end_byte);
                    n_phase = PH_HUNT;
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_BYTE_RST;
            r_end_byte   <= END_BYTE_RST;
            r_phase      <= PH_HUNT;
            r_cnt        <= '0;
            r_id         <= '0;
            r_len        <= '0;
            r_crc        <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_START_BYTE) begin
                    r_start_byte <= i_cfg_data;
                end
                if (i_cfg_idx == CFG_END_BYTE) begin
                    r_end_byte <= i_cfg_data;
                end
            end
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_id    <= n_id;
            r_len   <= n_len;
            r_crc   <= n_crc;
        end
    end

    assign o_ram_we    = n_we;
    assign o_ram_waddr = r_cnt[AW-1:0];
    assign o_ram_wdata = i_rx_byte;

    // header registers hold steady while the emitter drains, input being stalled
    assign o_req.start = n_start;
    assign o_req.id    = r_id;
    assign o_req.crc   = r_crc;
    assign o_req.len   = 8'(r_len);

endmodule

// ----- rtl/bfd_emitter.sv -----
`timescale 1ns / 1ps

module bfd_emitter #(
    parameter int MAX_PAYLOAD = 16,
    parameter int LEN_W       = $clog2(MAX_PAYLOAD + 1),
    parameter int AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bfd_pkg::t_emit_req i_req,
    output logic               o_busy,
    output logic               o_ram_re,
    output logic [AW-1:0]      o_ram_raddr,
    input  logic [7:0]         i_ram_rdata,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [15:0]        o_pkt_id,
    output logic [4:0]         o_payload_length,
    output logic [15:0]        o_received_crc,
    output logic [7:0]         o_payload_byte,
    output logic [3:0]         o_byte_index,
    output logic               o_has_data,
    output logic               o_last
);

    import bfd_pkg::*;

    logic             r_busy;
    logic [LEN_W-1:0] r_rd_cnt;
    logic             r_rd_pend;
    logic [LEN_W-1:0] r_rd_idx;
    logic             r_rd_last;
    logic             r_out_valid;
    logic [15:0]      r_pkt_id, r_crc;
    logic [4:0]       r_plen;
    logic [7:0]       r_byte;
    logic [3:0]       r_idx;
    logic             r_has_data, r_last;

    logic [LEN_W-1:0] w_len;
    logic [31:0]      w_len_ext, w_idx_ext;
    logic             w_out_free, w_issue, w_issue_last, w_empty;

    assign w_len        = LEN_W'(i_req.len);
    assign w_len_ext    = 32'(w_len);
    assign w_idx_ext    = 32'(r_rd_idx);
    assign w_out_free   = !r_out_valid || !i_stall;
    assign w_issue      = r_busy && !r_rd_pend && w_out_free && (w_len != '0);
    assign w_issue_last = w_issue && ((32'(r_rd_cnt) + 32'd1) == w_len_ext);
    assign w_empty      = r_busy && (w_len == '0) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_rd_cnt    <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.start) begin
                r_busy   <= 1'b1;
                r_rd_cnt <= '0;
            end else if (w_issue_last || w_empty) begin
                r_busy <= 1'b0;
            end
            if (w_issue) begin
                r_rd_cnt <= LEN_W'(r_rd_cnt + 1'b1);
            end
            r_rd_pend <= w_issue;
            if (r_rd_pend || w_empty) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd_idx  <= r_rd_cnt;
            r_rd_last <= w_issue_last;
        end
        if (r_rd_pend) begin
            r_pkt_id   <= i_req.id;
            r_crc      <= i_req.crc;
            r_plen     <= w_len_ext[4:0];
            r_byte     <= i_ram_rdata;
            r_idx      <= w_idx_ext[3:0];
            r_has_data <= 1'b1;
            r_last     <= r_rd_last;
        end else if (w_empty) begin
            r_pkt_id   <= i_req.id;
            r_crc      <= i_req.crc;
            r_plen     <= 5'd0;
            r_byte     <= 8'd0;
            r_idx      <= 4'd0;
            r_has_data <= 1'b0;
            r_last     <= 1'b1;
        end
    end

    assign o_busy           = r_busy;
    assign o_ram_re         = w_issue;
    assign o_ram_raddr      = r_rd_cnt[AW-1:0];
    assign o_valid          = r_out_valid;
    assign o_pkt_id         = r_pkt_id;
    assign o_payload_length = r_plen;
    assign o_received_crc   = r_crc;
    assign o_payload_byte   = r_byte;
    assign o_byte_index     = r_idx;
    assign o_has_data       = r_has_data;
    assign o_last           = r_last;

`include "byte_frame_deframer_assert.svh"

    // read data always lands in a free output register
    `BFD_ASSERT_IMPL(a_load_free, i_clk, i_rst_n, r_rd_pend, !r_out_valid)
    // no frame closes while the previous one is still being read out
    `BFD_ASSERT_IMPL(a_start_idle, i_clk, i_rst_n, i_req.start, !r_busy)
    // read pointer stays inside the frame
    `BFD_ASSERT_IMPL(a_rd_range, i_clk, i_rst_n, r_busy && (w_len != '0), r_rd_cnt < w_len)
    // the final read ends the burst
    `BFD_ASSERT_NEXT(a_last_done, i_clk, i_rst_n, w_issue_last, !r_busy && r_rd_pend)

endmodule

// ----- rtl/byte_frame_deframer.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_stall   i_rx_byte
// output    out        o_valid / i_stall   o_pkt_id .. o_last
// config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// Header and payload bytes are taken at one per cycle unless stalled; payload goes to a
// 1-port-write RAM. At a good end byte, input stalls while the RAM is read back: each
// result is a RAM read then an output register load; the next read waits for that load,
// and longer while the output stalls. A zero-length frame gives one result. Input resumes
// once the last read is issued; the final result may still wait in the output register.
// Reset is synchronous, active low; the payload RAM is not cleared.

module byte_frame_deframer #(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [7:0]                    i_rx_byte,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [15:0]                   o_pkt_id,
    output logic [4:0]                    o_payload_length,
    output logic [15:0]                   o_received_crc,
    output logic [7:0]                    o_payload_byte,
    output logic [3:0]                    o_byte_index,
    output logic                          o_has_data,
    output logic                          o_last,
    input  logic                          i_cfg_we,
    input  logic [bfd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                    i_cfg_data
);

    import bfd_pkg::*;

    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
    localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    t_emit_req     w_req;
    logic          w_busy;
    logic          w_accept;
    logic          w_we, w_re;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [7:0]    w_wdata, w_rdata;

    assign o_stall  = w_busy;
    assign w_accept = i_valid && !w_busy;

    bfd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .LEN_W       (LEN_W),
        .AW          (AW)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_ram_we    (w_we),
        .o_ram_waddr (w_waddr),
        .o_ram_wdata (w_wdata),
        .o_req       (w_req)
    );

    bfd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    bfd_emitter #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .LEN_W       (LEN_W),
        .AW          (AW)
    ) u_emitter (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req            (w_req),
        .o_busy           (w_busy),
        .o_ram_re         (w_re),
        .o_ram_raddr      (w_raddr),
        .i_ram_rdata      (w_rdata),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_pkt_id         (o_pkt_id),
        .o_payload_length (o_payload_length),
        .o_received_crc   (o_received_crc),
        .o_payload_byte   (o_payload_byte),
        .o_byte_index     (o_byte_index),
        .o_has_data       (o_has_data),
        .o_last           (o_last)
    );

endmodule

// ----- dv/byte_frame_deframer_checker.sv -----
`timescale 1ns / 1ps

module byte_frame_deframer_checker #(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [7:0]                    i_rx_byte,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [15:0]                   i_pkt_id,
    input  logic [4:0]                    i_payload_length,
    input  logic [15:0]                   i_received_crc,
    input  logic [7:0]                    i_payload_byte,
    input  logic [3:0]                    i_byte_index,
    input  logic                          i_has_data,
    input  logic                          i_last,
    input  logic                          i_cfg_we,
    input  logic [bfd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                    i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_checked
);

    typedef struct packed {
        logic [15:0] pkt_id;
        logic [4:0]  payload_length;
        logic [15:0] received_crc;
        logic [7:0]  payload_byte;
        logic [3:0]  byte_index;
        logic        has_data;
        logic        last;
    } t_beat;

    typedef enum logic [2:0] {
        SEEK_START,
        TAKE_ID,
        TAKE_LEN,
        TAKE_DATA,
        TAKE_CRC,
        TAKE_END
    } t_parse;

    t_parse      parse;
    logic [4:0]  field_cnt;
    logic [15:0] id_q;
    logic [4:0]  len_q;
    logic [15:0] crc_q;
    logic [7:0]  payload_mem [0:MAX_PAYLOAD-1];
    logic [7:0]  start_q;
    logic [7:0]  end_q;
    t_beat       expected_beats[$];
    int          fails;
    int          checked;

    assign o_fail_count = fails;
    assign o_checked    = checked;

    // Advance the frame parser by one byte; queue the frame's beats on a good end byte.
    task automatic deframe_byte(input logic [7:0] b);
        t_beat beat;
        int    k;
        case (parse)
            SEEK_START: begin
                if (b == start_q) begin
                    parse     = TAKE_ID;
                    field_cnt = 5'd0;
                end
            end
            TAKE_ID: begin
                if (field_cnt == 5'd0) begin
                    id_q[7:0] = b;
                    field_cnt = 5'd1;
                end else begin
                    id_q[15:8] = b;
                    field_cnt  = 5'd0;
                    parse      = TAKE_LEN;
                end
            end
            TAKE_LEN: begin
                if (b > MAX_PAYLOAD) begin
                    parse = SEEK_START;
                end else begin
                    len_q     = b[4:0];
                    field_cnt = 5'd0;
                    parse     = (b == 8'd0) ? TAKE_CRC : TAKE_DATA;
                end
            end
            TAKE_DATA: begin
                payload_mem[field_cnt[3:0]] = b;
                field_cnt = field_cnt + 5'd1;
                if (field_cnt >= len_q) begin
                    field_cnt = 5'd0;
                    parse     = TAKE_CRC;
                end
            end
            TAKE_CRC: begin
                if (field_cnt == 5'd0) begin
                    crc_q[7:0] = b;
                    field_cnt  = 5'd1;
                end else begin
                    crc_q[15:8] = b;
                    field_cnt   = 5'd0;
                    parse       = TAKE_END;
                end
            end
            TAKE_END: begin
                if (b == end_q) begin
                    beat.pkt_id       = id_q;
                    beat.received_crc = crc_q;
                    if (len_q == 5'd0) begin
                        beat.payload_length = 5'd0;
                        beat.payload_byte   = 8'd0;
                        beat.byte_index     = 4'd0;
                        beat.has_data       = 1'b0;
                        beat.last           = 1'b1;
                        expected_beats.push_back(beat);
                    end else begin
                        for (k = 0; k < len_q; k++) begin
                            beat.payload_length = len_q;
                            beat.payload_byte   = payload_mem[k];
                            beat.byte_index     = k[3:0];
                            beat.has_data       = 1'b1;
                            beat.last           = (k + 1 == len_q);
                            expected_beats.push_back(beat);
                        end
                    end
                end
                parse = SEEK_START;
            end
            default: parse = SEEK_START;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_beat got;
        t_beat want;
        got = {i_pkt_id, i_payload_length, i_received_crc, i_payload_byte,
               i_byte_index, i_has_data, i_last};
        if (!i_rst_n) begin
            parse     = SEEK_START;
            field_cnt = 5'd0;
            id_q      = 16'd0;
            len_q     = 5'd0;
            crc_q     = 16'd0;
            start_q   = bfd_pkg::START_BYTE_RST;
            end_q     = bfd_pkg::END_BYTE_RST;
            fails     = 0;
            checked   = 0;
            expected_beats.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bfd_pkg::CFG_START_BYTE: start_q = i_cfg_data;
                    bfd_pkg::CFG_END_BYTE:   end_q   = i_cfg_data;
                    default: ;
                endcase
            end
            // Compare the output transaction before this edge's input can queue more.
            if (i_out_valid && !i_out_stall) begin
                checked++;
                if (expected_beats.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("extra: id %h len %0d crc %h byte %h idx %0d dv %b last %b",
                                 got.pkt_id, got.payload_length, got.received_crc,
                                 got.payload_byte, got.byte_index, got.has_data, got.last);
                end else begin
                    want = expected_beats.pop_front();
                    if (got != want) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("exp id %h len %0d crc %h byte %h idx %0d dv %b last %b",
                                     want.pkt_id, want.payload_length, want.received_crc,
                                     want.payload_byte, want.byte_index, want.has_data,
                                     want.last);
                            $display("got id %h len %0d crc %h byte %h idx %0d dv %b last %b",
                                     got.pkt_id, got.payload_length, got.received_crc,
                                     got.payload_byte, got.byte_index, got.has_data,
                                     got.last);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                deframe_byte(i_rx_byte);
        end
        o_pending = expected_beats.size();
    end

endmodule

// ----- dv/byte_frame_deframer_tb.sv -----
`timescale 1ns / 1ps

module byte_frame_deframer_tb;

    import bfd_pkg::*;

    localparam int MAX_PAYLOAD  = 16;
    localparam int ITEMS        = 430;
    localparam int NUM_SETTINGS = 4;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_BURSTS
    } t_stall_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [7:0]           i_rx_byte;
    logic                 o_valid;
    logic                 i_stall;
    logic [15:0]          o_pkt_id;
    logic [4:0]           o_payload_length;
    logic [15:0]          o_received_crc;
    logic [7:0]           o_payload_byte;
    logic [3:0]           o_byte_index;
    logic                 o_has_data;
    logic                 o_last;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [7:0]           i_cfg_data;

    int fail_count;
    int pending;
    int checked;

    int          cycles      = 0;
    t_stall_mode stall_mode  = STALL_NONE;
    int          stall_hold  = 0;
    logic        stall_level = 1'b0;

    logic [7:0] cur_start;
    logic [7:0] cur_end;
    int         max_gap;
    int         burst_left;
    int         frame_bytes;
    int         n_good;
    int         n_bad_end;
    int         n_oversize;
    int         n_cut;

    byte_frame_deframer #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pkt_id        (o_pkt_id),
        .o_payload_length(o_payload_length),
        .o_received_crc  (o_received_crc),
        .o_payload_byte  (o_payload_byte),
        .o_byte_index    (o_byte_index),
        .o_has_data      (o_has_data),
        .o_last          (o_last),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    byte_frame_deframer_checker #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_rx_byte       (i_rx_byte),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_pkt_id        (o_pkt_id),
        .i_payload_length(o_payload_length),
        .i_received_crc  (o_received_crc),
        .i_payload_byte  (o_payload_byte),
        .i_byte_index    (o_byte_index),
        .i_has_data      (o_has_data),
        .i_last          (o_last),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("FAIL byte_frame_deframer");
            $finish;
        end
    end

    // Receiver back-pressure from a stall pattern that is redrawn at random.
    always @(negedge i_clk) begin
        if (cycles % 160 == 0)
            stall_mode = t_stall_mode'($urandom_range(0, 3));
        case (stall_mode)
            STALL_NONE:     i_stall = 1'b0;
            STALL_RANDOM:   i_stall = ($urandom_range(0, 99) < 35);
            STALL_PERIODIC: i_stall = ((cycles % 6) < 2);
            default: begin
                if (stall_hold == 0) begin
                    stall_level = ~stall_level;
                    stall_hold  = $urandom_range(1, 9);
                end
                stall_hold--;
                i_stall = stall_level;
            end
        endcase
    end

    // Present one byte and hold it until the transaction completes; called at a falling edge.
    task automatic put_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
            if (gap > 0) begin
                i_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_valid   = 1'b1;
        i_rx_byte = b;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
    endtask

    // fill below zero gives random payload, seeded now and then with the start byte.
    task automatic send_frame(input logic [15:0] id, input logic [7:0] len,
                              input logic [15:0] crc, input logic [7:0] tail,
                              input int fill);
        int k;
        put_byte(cur_start);
        put_byte(id[7:0]);
        put_byte(id[15:8]);
        put_byte(len);
        frame_bytes += 4;
        if (len <= MAX_PAYLOAD) begin
            for (k = 0; k < len; k++) begin
                if (fill >= 0)
                    put_byte(fill[7:0]);
                else if ($urandom_range(0, 7) == 0)
                    put_byte(cur_start);
                else
                    put_byte(8'($urandom_range(0, 255)));
            end
            put_byte(crc[7:0]);
            put_byte(crc[15:8]);
            put_byte(tail);
            frame_bytes += len + 3;
        end
    endtask

    task automatic drain();
        i_valid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic random_frame();
        int         pick;
        int         k;
        int         n;
        logic [7:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            len = 8'd0;
        else if (pick < 40)
            len = 8'(MAX_PAYLOAD);
        else
            len = 8'($urandom_range(1, MAX_PAYLOAD - 1));
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
            send_frame(16'($urandom_range(0, 65535)), len, 16'($urandom_range(0, 65535)),
                       cur_end, -1);
            n_good++;
        end else if (pick < 74) begin
            send_frame(16'($urandom_range(0, 65535)), len, 16'($urandom_range(0, 65535)),
                       cur_end ^ 8'($urandom_range(1, 255)), -1);
            n_bad_end++;
        end else if (pick < 84) begin
            send_frame(16'($urandom_range(0, 65535)),
                       8'($urandom_range(MAX_PAYLOAD + 1, 255)), 16'd0, cur_end, -1);
            n_oversize++;
        end else if (pick < 92) begin
            // Cut a frame short; the next frame's bytes are parsed as its continuation.
            n = $urandom_range(1, 6);
            put_byte(cur_start);
            for (k = 0; k < n; k++)
                put_byte(8'($urandom_range(0, 255)));
            frame_bytes += n + 1;
            n_cut++;
        end else begin
            n = $urandom_range(1, 5);
            for (k = 0; k < n; k++)
                put_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int ph;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_rx_byte   = 8'd0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_START_BYTE;
        i_cfg_data  = 8'd0;
        cur_start   = START_BYTE_RST;
        cur_end     = END_BYTE_RST;
        max_gap     = 0;
        burst_left  = 0;
        frame_bytes = 0;
        n_good      = 0;
        n_bad_end   = 0;
        n_oversize  = 0;
        n_cut       = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: empty frame, length just over the limit, wrong end byte,
        // and start byte carried as payload.
        send_frame(16'hFFFF, 8'd0, 16'h0000, cur_end, -1);
        send_frame(16'h0000, 8'(MAX_PAYLOAD + 1), 16'h0000, cur_end, -1);
        send_frame(16'h3412, 8'd0, 16'hABCD, ~cur_end, -1);
        send_frame(16'h0000, 8'd2, 16'hFFFF, cur_end, cur_start);
        n_good     += 2;
        n_bad_end  += 1;
        n_oversize += 1;
        drain();

        for (ph = 0; ph < NUM_SETTINGS; ph++) begin
            case (ph)
                0: begin
                    cur_start = START_BYTE_RST;
                    cur_end   = END_BYTE_RST;
                end
                1: begin
                    cur_start = 8'h00;
                    cur_end   = 8'hFF;
                end
                2: begin
                    cur_start = 8'hFF;
                    cur_end   = 8'h00;
                end
                default: begin
                    cur_start = 8'($urandom_range(0, 255));
                    cur_end   = 8'($urandom_range(0, 255));
                end
            endcase
            write_reg(CFG_START_BYTE, cur_start);
            write_reg(CFG_END_BYTE, cur_end);
            max_gap = (ph == 0) ? 0 : $urandom_range(2, 8);
            while (frame_bytes < (ph + 1) * ITEMS / NUM_SETTINGS)
                random_frame();
            drain();
        end

        $display("Checked %0d results: %0d good, %0d bad-end, %0d oversized, %0d cut frames",
                 checked, n_good, n_bad_end, n_oversize, n_cut);
        $display("Sent %0d frame bytes across %0d start/end byte settings",
                 frame_bytes, NUM_SETTINGS);
        if (fail_count == 0 && pending == 0)
            $display("PASS byte_frame_deframer");
        else
            $display("FAIL byte_frame_deframer");
        $finish;
    end

endmodule

// ----- byte_frame_deframer.f -----
+incdir+rtl
rtl/bfd_pkg.sv
rtl/bfd_ram.sv
rtl/bfd_parser.sv
rtl/bfd_emitter.sv
rtl/byte_frame_deframer.sv
dv/byte_frame_deframer_checker.sv
dv/byte_frame_deframer_tb.sv
